### rtl/sdr_pkg.sv
`timescale 1ns / 1ps
package sdr_pkg;

  localparam int VALUE_W      = 32;
  localparam int KEPT_W       = 8;
  localparam int CAPACITY_DEF = 128;

  // controller -> datapath
  typedef struct packed {
    logic start;    // load request, clear scan state
    logic scan_en;  // step the table scan
    logic finish;   // commit table update and result
  } sdr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // compare stage matched this cycle
    logic scan_done;  // no reads left in flight, none left to issue
    logic out_free;   // result register can take a new result
  } sdr_status_t;

  // float equality: signed zeros equal, NaN equals nothing
  function automatic logic fp_equal(input logic [VALUE_W-1:0] a,
                                    input logic [VALUE_W-1:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[VALUE_W-2:0] > 31'h7F80_0000);
    b_nan = (b[VALUE_W-2:0] > 31'h7F80_0000);
    if (a_nan || b_nan) begin
      return 1'b0;
    end else if ((a[VALUE_W-2:0] | b[VALUE_W-2:0]) == '0) begin
      return 1'b1;
    end else begin
      return (a == b);
    end
  endfunction

endpackage

### rtl/sdr_ram.sv
`timescale 1ns / 1ps
module sdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/sdr_ctrl.sv
`timescale 1ns / 1ps
module sdr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdr_pkg::sdr_status_t status,
  output sdr_pkg::sdr_cmd_t    cmd
);
  import sdr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state;

  // command decode
  always_comb begin
    in_ready    = (state == S_IDLE);
    cmd.start   = (state == S_IDLE) && in_valid;
    cmd.scan_en = (state == S_SCAN);
    cmd.finish  = (state == S_FIN) && status.out_free;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (status.hit || status.scan_done) state <= S_FIN;
        end
        S_FIN: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/sdr_dp.sv
`timescale 1ns / 1ps
module sdr_dp #(
  parameter int CAPACITY = sdr_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sdr_pkg::sdr_cmd_t               cmd,
  output sdr_pkg::sdr_status_t            status,
  input  logic [sdr_pkg::VALUE_W-1:0]     value_bits,
  input  logic                            end_of_array,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sdr_pkg::VALUE_W-1:0]     out_value,
  output logic                            is_first,
  output logic [sdr_pkg::KEPT_W-1:0]      kept_count,
  output logic                            table_overflow,
  output logic                            out_last
);
  import sdr_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [VALUE_W-1:0] value;
  logic               last;
  logic               found;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rd_idx;
  logic               cmp_valid;
  logic [VALUE_W-1:0] rd_data;
  logic               issue;
  logic               full;
  logic               store;
  logic [CW-1:0]      count_next;
  logic [31:0]        count_wide;

  // table storage
  sdr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (count[AW-1:0]),
    .wr_data (value),
    .rd_en   (issue),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // scan control and table update
  always_comb begin
    issue      = cmd.scan_en && (rd_idx != count);
    full       = (count == CAP_C);
    store      = cmd.finish && !found && !full;
    count_next = store ? count + CW'(1) : count;
    count_wide = 32'(count_next);
    status.hit       = cmd.scan_en && cmp_valid && fp_equal(rd_data, value);
    status.scan_done = (rd_idx == count) && !cmp_valid;
    status.out_free  = !out_valid || out_ready;
  end

  // request capture and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      value <= value_bits;
      last  <= end_of_array;
    end
    if (rst) begin
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.start) begin
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.scan_en) begin
      cmp_valid <= issue;
      if (issue) rd_idx <= rd_idx + CW'(1);
      if (status.hit) found <= 1'b1;
    end
  end

  // stored count, cleared after the last element
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= last ? '0 : count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      out_value      <= value;
      is_first       <= !found;
      kept_count     <= (count_wide > 32'd255) ? 8'hFF : count_wide[KEPT_W-1:0];
      table_overflow <= !found && full;
      out_last       <= last;
    end
  end

endmodule

### rtl/stream_duplicate_remover_unit.sv
`timescale 1ns / 1ps
// Operation: a request is captured, then the table scan compares it against the
//   values stored (0..CAPACITY); a match ends the scan early. The table scan
//   reads one entry per cycle from the registered RAM port.
// Throughput: one request at a time; the next request is taken only after the
//   result is committed, which an output stall can delay.
// Reset (rst, synchronous, active high): empty table, no result pending; table
//   contents are not cleared, entries are only read after being written.
module stream_duplicate_remover_unit #(
  parameter int CAPACITY = sdr_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sdr_pkg::VALUE_W-1:0] value_bits,
  input  logic                        end_of_array,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sdr_pkg::VALUE_W-1:0] out_value,
  output logic                        is_first,
  output logic [sdr_pkg::KEPT_W-1:0]  kept_count,
  output logic                        table_overflow,
  output logic                        out_last
);
  import sdr_pkg::*;

  sdr_cmd_t    cmd;
  sdr_status_t status;

  // sequencer
  sdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // table, compare and result
  sdr_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .value_bits     (value_bits),
    .end_of_array   (end_of_array),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .is_first       (is_first),
    .kept_count     (kept_count),
    .table_overflow (table_overflow),
    .out_last       (out_last)
  );

endmodule
